// File: src/sqbs_pkg.sv
`default_nettype none

package sqbs_pkg;

  localparam int SQBS_TEXTURE_SLOTS = 32;
  localparam int SQBS_MAX_QUADS     = 8192;

  localparam int IN_DATA_W  = 256;
  localparam int OUT_DATA_W = 168;
  localparam int PROD_W     = 48;
  localparam int ACC_W      = 51;
  localparam int FRAC_SHIFT = 15;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(16384);

  localparam logic MODE_DRAW   = 1'b0;
  localparam logic MODE_END    = 1'b1;
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  typedef struct packed {
    logic        [15:0] tex_scale;
    logic        [31:0] color_in;
    logic        [15:0] texture_id;
    logic signed [15:0] sin_angle;
    logic signed [15:0] cos_angle;
    logic signed [31:0] size_y;
    logic signed [31:0] size_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } sqbs_req_t;

  typedef struct packed {
    logic        [1:0]  pad;
    logic        [13:0] batch_count;
    logic        [15:0] scale_out;
    logic        [5:0]  tex_slot;
    logic        [31:0] color_out;
    logic               tex_v;
    logic               tex_u;
    logic signed [31:0] vertex_z;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_x;
  } sqbs_vtx_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-FRAC_SHIFT-1:0] v);
    logic signed [31:0] r;
    if (v > (ACC_W-FRAC_SHIFT)'(64'sh7FFF_FFFF)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -(ACC_W-FRAC_SHIFT)'(64'sh8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/sprite_quad_batch_setup.sv
// Sprite quad setup for a batch renderer.
// Slave stream: one word per request; tuser = mode (0 draw, 1 end scene).
// Master stream: vertex and flush words; tuser = kind (0 vertex, 1 flush),
// tlast marks the final word caused by a request.
// A draw emits four corner vertices, preceded by a flush word when the batch
// or the texture slot table is full. End scene emits one flush word.
// Flow: ready only while the sequencer idles. An untextured draw goes from
// accept through lookup, the multiply steps and the vertex words back to
// idle; an end scene passes through the flush state alone. A textured draw
// adds a probe per slot table entry (one memory read and one compare each)
// and the miss state on a miss. A full batch adds its flush word, a full slot
// table a flush word, then a fresh lookup that lands in slot 1.
// The single 32x16 multiplier forms a quad's products in turn; the output
// register then drains one vertex per cycle while the receiver accepts.
// When the receiver stalls, the output word holds and the sequencer waits.
// Reset leaves one slot in use (white) and an empty batch; the slot table
// needs no clearing since only written entries are ever probed.
`default_nettype none

module sprite_quad_batch_setup
  import sqbs_pkg::*;
#(
  parameter int TEXTURE_SLOTS = SQBS_TEXTURE_SLOTS,
  parameter int MAX_QUADS     = SQBS_MAX_QUADS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output      logic                  s_axis_tready_o,
  // pos_x, pos_y, pos_z, size_x, size_y, cos_angle, sin_angle, texture_id,
  // color_in, tex_scale
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // mode
  input  wire logic                  s_axis_tuser_i,
  output      logic                  m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // vertex_x, vertex_y, vertex_z, tex_u, tex_v, color_out, tex_slot,
  // scale_out, batch_count, 2 zero bits
  output      logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // kind
  output      logic                  m_axis_tuser_o,
  output      logic                  m_axis_tlast_o
);

  localparam int IW = $clog2(TEXTURE_SLOTS + 1);
  localparam int AW = $clog2(TEXTURE_SLOTS);
  localparam int BW = $clog2(MAX_QUADS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FLUSH  = 4'd1;
  localparam logic [3:0] S_LOOKUP = 4'd2;
  localparam logic [3:0] S_READ   = 4'd3;
  localparam logic [3:0] S_CMP    = 4'd4;
  localparam logic [3:0] S_MISS   = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_VTX    = 4'd7;

  localparam logic [1:0] LAST_STEP = 2'd3;

  logic [3:0]    state_q, state_d;
  logic [IW-1:0] used_q, used_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] slot_q, slot_d;
  logic [BW-1:0] batch_q, batch_d;
  logic [1:0]    step_q, step_d;
  logic          flush_last_q, flush_last_d;
  logic          out_valid_q, out_valid_d;

  sqbs_req_t          req_q;
  logic signed [PROD_W-1:0] prod_q [4];
  logic        [15:0] rdata_q;
  logic        [15:0] slot_mem [TEXTURE_SLOTS];
  sqbs_vtx_t          out_data_q;
  logic               out_user_q;
  logic               out_last_q;

  logic        in_fire;
  logic        out_free;
  logic        req_load;
  logic        rd_en;
  logic        mem_we;
  logic        mul_en;
  logic        out_load;
  sqbs_vtx_t   out_item;
  logic        out_kind;
  logic        out_lst;

  logic signed [31:0]       mul_a;
  logic signed [15:0]       mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     sx_neg;
  logic                     sy_neg;
  logic signed [ACC_W-1:0]  pos_x_ext;
  logic signed [ACC_W-1:0]  pos_y_ext;
  logic signed [ACC_W-1:0]  t_cx, t_sy, t_sx, t_cy;
  logic signed [ACC_W-1:0]  x_sum, y_sum;
  logic signed [31:0]       vx, vy;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

  // shared multiplier: cos*size_x, sin*size_y, sin*size_x, cos*size_y
  assign mul_a = step_q[0] ? req_q.size_y : req_q.size_x;
  assign mul_b = (step_q[0] ^ step_q[1]) ? req_q.sin_angle : req_q.cos_angle;
  assign mul_p = mul_a * mul_b;

  // corner order: (-,-), (+,-), (+,+), (-,+)
  always_comb begin
    sx_neg    = ~(step_q[1] ^ step_q[0]);
    sy_neg    = ~step_q[1];
    pos_x_ext = $signed({{(ACC_W-32-FRAC_SHIFT){req_q.pos_x[31]}}, req_q.pos_x,
                         {FRAC_SHIFT{1'b0}}});
    pos_y_ext = $signed({{(ACC_W-32-FRAC_SHIFT){req_q.pos_y[31]}}, req_q.pos_y,
                         {FRAC_SHIFT{1'b0}}});
    t_cx  = sx_neg ? -ACC_W'(prod_q[0]) : ACC_W'(prod_q[0]);
    t_sy  = sy_neg ?  ACC_W'(prod_q[1]) : -ACC_W'(prod_q[1]);
    t_sx  = sx_neg ? -ACC_W'(prod_q[2]) : ACC_W'(prod_q[2]);
    t_cy  = sy_neg ? -ACC_W'(prod_q[3]) : ACC_W'(prod_q[3]);
    x_sum = pos_x_ext + t_cx + t_sy + $signed(ROUND_HALF);
    y_sum = pos_y_ext + t_sx + t_cy + $signed(ROUND_HALF);
    vx    = sat32(x_sum[ACC_W-1:FRAC_SHIFT]);
    vy    = sat32(y_sum[ACC_W-1:FRAC_SHIFT]);
  end

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    batch_d      = batch_q;
    step_d       = step_q;
    flush_last_d = flush_last_q;
    req_load     = 1'b0;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    mul_en       = 1'b0;
    out_load     = 1'b0;
    out_item     = '0;
    out_kind     = KIND_VERTEX;
    out_lst      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          req_load = 1'b1;
          if (s_axis_tuser_i == MODE_END) begin
            flush_last_d = 1'b1;
            state_d      = S_FLUSH;
          end else if (batch_q >= BW'(MAX_QUADS)) begin
            flush_last_d = 1'b0;
            state_d      = S_FLUSH;
          end else begin
            state_d = S_LOOKUP;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_kind             = KIND_FLUSH;
          out_lst              = flush_last_q;
          out_item.tex_slot    = 6'(used_q);
          out_item.batch_count = 14'(batch_q);
          used_d               = IW'(1);
          batch_d              = '0;
          state_d              = flush_last_q ? S_IDLE : S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (req_q.texture_id == '0) begin
          slot_d  = '0;
          step_d  = '0;
          state_d = S_MUL;
        end else begin
          idx_d   = IW'(1);
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (idx_q >= used_q) begin
          state_d = S_MISS;
        end else begin
          rd_en   = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (rdata_q == req_q.texture_id) begin
          slot_d  = idx_q;
          step_d  = '0;
          state_d = S_MUL;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_READ;
        end
      end
      S_MISS: begin
        if (used_q >= IW'(TEXTURE_SLOTS)) begin
          flush_last_d = 1'b0;
          state_d      = S_FLUSH;
        end else begin
          mem_we  = 1'b1;
          slot_d  = used_q;
          used_d  = used_q + IW'(1);
          step_d  = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        mul_en = 1'b1;
        step_d = step_q + 2'd1;
        if (step_q == LAST_STEP) begin
          state_d = S_VTX;
        end
      end
      S_VTX: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_lst            = (step_q == LAST_STEP);
          out_item.vertex_x  = vx;
          out_item.vertex_y  = vy;
          out_item.vertex_z  = req_q.pos_z;
          out_item.tex_u     = step_q[1] ^ step_q[0];
          out_item.tex_v     = step_q[1];
          out_item.color_out = req_q.color_in;
          out_item.tex_slot  = 6'(slot_q);
          out_item.scale_out = req_q.tex_scale;
          step_d             = step_q + 2'd1;
          if (step_q == LAST_STEP) begin
            batch_d = batch_q + BW'(1);
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= IW'(1);
      idx_q        <= '0;
      slot_q       <= '0;
      batch_q      <= '0;
      step_q       <= '0;
      flush_last_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      idx_q        <= idx_d;
      slot_q       <= slot_d;
      batch_q      <= batch_d;
      step_q       <= step_d;
      flush_last_q <= flush_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_load) begin
      req_q <= sqbs_req_t'(s_axis_tdata_i);
    end
    if (mul_en) begin
      prod_q[step_q] <= mul_p;
    end
    if (out_load) begin
      out_data_q <= out_item;
      out_user_q <= out_kind;
      out_last_q <= out_lst;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[used_q[AW-1:0]] <= req_q.texture_id;
    end
    if (rd_en) begin
      rdata_q <= slot_mem[idx_q[AW-1:0]];
    end
  end

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q >= IW'(1)) && (used_q <= IW'(TEXTURE_SLOTS)))
    else $error("slot count out of range");

  a_batch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    batch_q <= BW'(MAX_QUADS))
    else $error("batch count exceeds limit");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (state_q == S_FLUSH)) |=> ((used_q == IW'(1)) && (batch_q == '0)))
    else $error("flush did not restart batch");

  a_vertex_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VTX) |-> (slot_q < used_q))
    else $error("vertex slot not allocated");

endmodule

`default_nettype wire
